[src/ssf_pkg.sv]
// Package for the stiff string finite-difference step core.
// Holds sizes, register indexes, state codes and control structs.
// No dependencies.
`timescale 1ns / 1ps

package ssf_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int MIN_POINTS   = 4;
    localparam int GRID_DEPTH   = MAX_POINTS + 1;
    localparam int ADDR_W       = $clog2(GRID_DEPTH);
    localparam int NUM_GRIDS    = 3;
    localparam int SAMPLE_WIDTH = 32;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 16;
    localparam int GAIN_W       = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int FRAC_BITS    = 28;
    localparam int GAIN_FRAC    = 16;
    localparam int OP_W         = DATA_W + 1;
    localparam int PROD_W       = 2 * OP_W;
    localparam int ACC_W        = PROD_W + 1;

    localparam logic [ADDR_W-1:0] GRID_POINTS_RST = ADDR_W'(64);
    localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST = GAIN_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_POINTS      = 3'd0,
        CFG_COEF_CENTER_NOW  = 3'd1,
        CFG_COEF_NEAR_NOW    = 3'd2,
        CFG_COEF_FAR_NOW     = 3'd3,
        CFG_COEF_CENTER_PREV = 3'd4,
        CFG_COEF_NEAR_PREV   = 3'd5,
        CFG_OUTPUT_GAIN      = 3'd6
    } cfg_reg_t;

    typedef logic [1:0] grid_sel_t;
    localparam grid_sel_t GRID_A = 2'd0;
    localparam grid_sel_t GRID_B = 2'd1;
    localparam grid_sel_t GRID_C = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POS_MUL,
        S_POS_CAP,
        S_FETCH,
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_WRITE,
        S_END,
        S_OUT_MUL,
        S_OUT_RND
    } seq_state_t;

    // one product per tap of the stencil
    typedef enum logic [2:0] {
        TAP_CC,
        TAP_CN_L,
        TAP_CN_R,
        TAP_CF_L,
        TAP_CF_R,
        TAP_PC,
        TAP_PN_L,
        TAP_PN_R
    } tap_t;

    typedef struct packed {
        logic        [ADDR_W-1:0] grid_points;
        logic signed [DATA_W-1:0] coef_center_now;
        logic signed [DATA_W-1:0] coef_near_now;
        logic signed [DATA_W-1:0] coef_far_now;
        logic signed [DATA_W-1:0] coef_center_prev;
        logic signed [DATA_W-1:0] coef_near_prev;
        logic        [GAIN_W-1:0] output_gain;
    } cfg_t;

    typedef struct packed {
        logic                     wr_all;
        logic                     wr_new;
        logic        [ADDR_W-1:0] wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic        [ADDR_W-1:0] fetch_addr;
    } mem_ctrl_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } mac_ctrl_t;

endpackage

[src/stiff_string_fdtd_step_core.sv]
// Stiff string finite-difference step core, top level.
// Tick: a sweep over the grid points, each point computed one after another on the
// shared 33x33 multiplier (8 products, operand fetch, drain, write back).
// Excite transactions are taken while idle. One transaction in flight; the result
// waits in an output register while excite transactions are taken.
// Reset: asynchronous, then a clearing pass over the three grids.
`timescale 1ns / 1ps

module stiff_string_fdtd_step_core import ssf_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic        [CFG_INDEX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic        [POS_W-1:0]        output_position,
    input  logic        [ADDR_W-1:0]       point_index,
    input  logic signed [DATA_W-1:0]       point_value,
    input  logic                           strike,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample
);

    cfg_t                           cfg_reg;
    grid_sel_t                      phase_reg, phase_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;

    logic        [ADDR_W-1:0] eff_n;
    grid_sel_t                nw_sel, cur_sel, prv_sel;
    logic                     exc_ok;
    logic                     out_load;
    logic                     rotate;
    mem_ctrl_t                mem_ctrl;
    mac_ctrl_t                mac_ctrl;
    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0] product;
    logic signed [DATA_W-1:0] stencil_res;
    logic signed [SAMPLE_WIDTH-1:0] sample_res;
    logic signed [DATA_W-1:0] cur_rdata, prv_rdata;

    logic                     grid_we    [NUM_GRIDS];
    logic        [ADDR_W-1:0] grid_waddr [NUM_GRIDS];
    logic signed [DATA_W-1:0] grid_wdata [NUM_GRIDS];
    logic        [ADDR_W-1:0] grid_raddr [NUM_GRIDS];
    logic signed [DATA_W-1:0] grid_rdata [NUM_GRIDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_points      <= GRID_POINTS_RST;
            cfg_reg.coef_center_now  <= '0;
            cfg_reg.coef_near_now    <= '0;
            cfg_reg.coef_far_now     <= '0;
            cfg_reg.coef_center_prev <= '0;
            cfg_reg.coef_near_prev   <= '0;
            cfg_reg.output_gain      <= OUTPUT_GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRID_POINTS:      cfg_reg.grid_points      <= cfg_data[ADDR_W-1:0];
                CFG_COEF_CENTER_NOW:  cfg_reg.coef_center_now  <= $signed(cfg_data);
                CFG_COEF_NEAR_NOW:    cfg_reg.coef_near_now    <= $signed(cfg_data);
                CFG_COEF_FAR_NOW:     cfg_reg.coef_far_now     <= $signed(cfg_data);
                CFG_COEF_CENTER_PREV: cfg_reg.coef_center_prev <= $signed(cfg_data);
                CFG_COEF_NEAR_PREV:   cfg_reg.coef_near_prev   <= $signed(cfg_data);
                CFG_OUTPUT_GAIN:      cfg_reg.output_gain      <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= GRID_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_reg <= sample_res;
        end
    end

    always_comb
    begin
        if (cfg_reg.grid_points < ADDR_W'(MIN_POINTS))
        begin
            eff_n = ADDR_W'(MIN_POINTS);
        end
        else if (cfg_reg.grid_points > ADDR_W'(MAX_POINTS))
        begin
            eff_n = ADDR_W'(MAX_POINTS);
        end
        else
        begin
            eff_n = cfg_reg.grid_points;
        end
    end

    // grid roles; the unused phase code acts as the first one
    always_comb
    begin
        case (phase_reg)
            GRID_B:
            begin
                nw_sel  = GRID_B;
                cur_sel = GRID_C;
                prv_sel = GRID_A;
            end
            GRID_C:
            begin
                nw_sel  = GRID_C;
                cur_sel = GRID_A;
                prv_sel = GRID_B;
            end
            default:
            begin
                nw_sel  = GRID_A;
                cur_sel = GRID_B;
                prv_sel = GRID_C;
            end
        endcase
    end

    assign phase_next = rotate ? prv_sel : phase_reg;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign exc_ok = in_valid && in_ready && kind && (point_index != '0)
                    && (point_index <= eff_n - ADDR_W'(2));

    always_comb
    begin
        for (int g = 0; g < NUM_GRIDS; g++)
        begin
            grid_we[g] = mem_ctrl.wr_all
                         || (mem_ctrl.wr_new && (nw_sel == 2'(g)))
                         || (exc_ok && (prv_sel == 2'(g)))
                         || (exc_ok && !strike && (cur_sel == 2'(g)));
            grid_waddr[g] = exc_ok ? point_index : mem_ctrl.wr_addr;
            grid_wdata[g] = exc_ok ? point_value : mem_ctrl.wr_data;
            grid_raddr[g] = (cur_sel == 2'(g)) ? mem_ctrl.fetch_addr
                                               : mem_ctrl.fetch_addr - 1'b1;
        end
    end

    assign cur_rdata = grid_rdata[cur_sel];
    assign prv_rdata = grid_rdata[prv_sel];

    for (genvar g = 0; g < NUM_GRIDS; g++)
    begin : g_grid
        ssf_grid_mem u_mem (
            .clk   (clk),
            .we    (grid_we[g]),
            .waddr (grid_waddr[g]),
            .wdata (grid_wdata[g]),
            .raddr (grid_raddr[g]),
            .rdata (grid_rdata[g])
        );
    end

    ssf_mac u_mac (
        .clk         (clk),
        .ctrl        (mac_ctrl),
        .op_a        (op_a),
        .op_b        (op_b),
        .product     (product),
        .stencil_res (stencil_res),
        .sample_res  (sample_res)
    );

    ssf_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .eff_n           (eff_n),
        .in_valid        (in_valid),
        .kind            (kind),
        .output_position (output_position),
        .in_ready        (in_ready),
        .out_valid       (out_valid_reg),
        .out_ready       (out_ready),
        .out_load        (out_load),
        .rotate          (rotate),
        .mem_ctrl        (mem_ctrl),
        .cur_rdata       (cur_rdata),
        .prv_rdata       (prv_rdata),
        .mac_ctrl        (mac_ctrl),
        .op_a            (op_a),
        .op_b            (op_b),
        .product         (product),
        .stencil_res     (stencil_res)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

[src/ssf_grid_mem.sv]
// One displacement grid: single write port, single registered read port.
// Depends on ssf_pkg for depth and widths.
`timescale 1ns / 1ps

module ssf_grid_mem import ssf_pkg::*; (
    input  logic                     clk,
    input  logic                     we,
    input  logic        [ADDR_W-1:0] waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic        [ADDR_W-1:0] raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [GRID_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/ssf_mac.sv]
// Shared multiplier with accumulator, stencil rounding and output scaling.
// Depends on ssf_pkg.
`timescale 1ns / 1ps

module ssf_mac import ssf_pkg::*; (
    input  logic                           clk,
    input  mac_ctrl_t                      ctrl,
    input  logic signed [OP_W-1:0]         op_a,
    input  logic signed [OP_W-1:0]         op_b,
    output logic signed [PROD_W-1:0]       product,
    output logic signed [DATA_W-1:0]       stencil_res,
    output logic signed [SAMPLE_WIDTH-1:0] sample_res
);

    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] STEN_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] STEN_MIN =
        {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] PROD_HALF =
        {{(PROD_W-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SMP_MAX =
        {{(PROD_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SMP_MIN =
        {{(PROD_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] product_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_q;
    logic signed [PROD_W-1:0] prod_sum;
    logic signed [PROD_W-1:0] prod_q;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            product_reg <= op_a * op_b;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + {product_reg[PROD_W-1], product_reg};
        end
    end

    // round half up, then saturate
    always_comb
    begin
        acc_sum = acc_reg + ACC_HALF;
        acc_q   = acc_sum >>> FRAC_BITS;
        if (acc_q > STEN_MAX)
        begin
            stencil_res = STEN_MAX[DATA_W-1:0];
        end
        else if (acc_q < STEN_MIN)
        begin
            stencil_res = STEN_MIN[DATA_W-1:0];
        end
        else
        begin
            stencil_res = acc_q[DATA_W-1:0];
        end

        prod_sum = product_reg + PROD_HALF;
        prod_q   = prod_sum >>> GAIN_FRAC;
        if (prod_q > SMP_MAX)
        begin
            sample_res = SMP_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (prod_q < SMP_MIN)
        begin
            sample_res = SMP_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sample_res = prod_q[SAMPLE_WIDTH-1:0];
        end
    end

    assign product = product_reg;

endmodule

[src/ssf_seq.sv]
// Sequencer: clearing pass, stencil sweep with a sliding operand window,
// pickup index and output scaling on the shared multiplier.
// Depends on ssf_pkg; drives ssf_mac and the grid memories.
`timescale 1ns / 1ps

module ssf_seq import ssf_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic        [ADDR_W-1:0] eff_n,
    input  logic                     in_valid,
    input  logic                     kind,
    input  logic        [POS_W-1:0]  output_position,
    output logic                     in_ready,
    input  logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_load,
    output logic                     rotate,
    output mem_ctrl_t                mem_ctrl,
    input  logic signed [DATA_W-1:0] cur_rdata,
    input  logic signed [DATA_W-1:0] prv_rdata,
    output mac_ctrl_t                mac_ctrl,
    output logic signed [OP_W-1:0]   op_a,
    output logic signed [OP_W-1:0]   op_b,
    input  logic signed [PROD_W-1:0] product,
    input  logic signed [DATA_W-1:0] stencil_res
);

    localparam int POS_SUM_W = POS_W + ADDR_W + 1;
    localparam logic [POS_SUM_W-1:0] POS_HALF = POS_SUM_W'(1) << (POS_W - 1);
    localparam int PRELOAD   = 3;

    seq_state_t               state_reg, state_next;
    logic        [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic        [ADDR_W-1:0] f_reg, f_next;
    logic        [ADDR_W-1:0] l_reg, l_next;
    tap_t                     k_reg, k_next;
    logic        [POS_W-1:0]  pos_reg, pos_next;
    logic        [ADDR_W-1:0] idx_reg, idx_next;
    logic signed [DATA_W-1:0] pick_reg, pick_next;
    logic                     cur_zero_reg, cur_zero_next;
    logic                     prv_zero_reg, prv_zero_next;
    logic signed [DATA_W-1:0] w_cur_reg [5];
    logic signed [DATA_W-1:0] w_cur_next [5];
    logic signed [DATA_W-1:0] w_prv_reg [3];
    logic signed [DATA_W-1:0] w_prv_next [3];

    logic [POS_SUM_W-1:0] pos_sum;
    logic [ADDR_W:0]      pos_rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg        <= f_next;
        l_reg        <= l_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        pick_reg     <= pick_next;
        cur_zero_reg <= cur_zero_next;
        prv_zero_reg <= prv_zero_next;
        w_cur_reg    <= w_cur_next;
        w_prv_reg    <= w_prv_next;
    end

    assign pos_sum = {1'b0, product[POS_W+ADDR_W-1:0]} + POS_HALF;
    assign pos_rnd = pos_sum[POS_SUM_W-1:POS_W];

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        f_next        = f_reg;
        l_next        = l_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        pick_next     = pick_reg;
        cur_zero_next = cur_zero_reg;
        prv_zero_next = prv_zero_reg;
        w_cur_next    = w_cur_reg;
        w_prv_next    = w_prv_reg;

        in_ready = 1'b0;
        out_load = 1'b0;
        rotate   = 1'b0;
        mem_ctrl = '{wr_all: 1'b0, wr_new: 1'b0, wr_addr: f_reg, wr_data: '0,
                     fetch_addr: f_reg};
        mac_ctrl = '{mul_en: 1'b0, acc_clr: 1'b0, acc_add: 1'b0};
        op_a     = '0;
        op_b     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_ctrl.wr_all  = 1'b1;
                mem_ctrl.wr_addr = clr_cnt_reg;
                clr_cnt_next     = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(GRID_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !kind)
                begin
                    pos_next   = output_position;
                    pick_next  = '0;
                    l_next     = ADDR_W'(1);
                    f_next     = '0;
                    state_next = S_POS_MUL;
                end
            end
            S_POS_MUL:
            begin
                op_a            = {{(OP_W-POS_W){1'b0}}, pos_reg};
                op_b            = {{(OP_W-ADDR_W){1'b0}}, eff_n};
                mac_ctrl.mul_en = 1'b1;
                state_next      = S_POS_CAP;
            end
            S_POS_CAP:
            begin
                if (pos_rnd > {1'b0, eff_n})
                begin
                    idx_next = eff_n;
                end
                else
                begin
                    idx_next = pos_rnd[ADDR_W-1:0];
                end
                mem_ctrl.wr_new  = 1'b1;
                mem_ctrl.wr_addr = '0;
                for (int i = 0; i < 5; i++)
                begin
                    w_cur_next[i] = '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    w_prv_next[i] = '0;
                end
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cur_zero_next = (f_reg > eff_n);
                prv_zero_next = (f_reg == '0);
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    w_cur_next[i] = w_cur_reg[i+1];
                end
                w_cur_next[4] = cur_zero_reg ? '0 : cur_rdata;
                w_prv_next[0] = w_prv_reg[1];
                w_prv_next[1] = w_prv_reg[2];
                w_prv_next[2] = prv_zero_reg ? '0 : prv_rdata;
                f_next        = f_reg + 1'b1;
                if (f_reg < ADDR_W'(PRELOAD))
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    k_next     = TAP_CC;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_clr = (k_reg == TAP_CC);
                mac_ctrl.acc_add = (k_reg != TAP_CC);
                case (k_reg)
                    TAP_CC:
                    begin
                        op_a = {cfg.coef_center_now[DATA_W-1], cfg.coef_center_now};
                        op_b = {w_cur_reg[2][DATA_W-1], w_cur_reg[2]};
                    end
                    TAP_CN_L:
                    begin
                        op_a = {cfg.coef_near_now[DATA_W-1], cfg.coef_near_now};
                        op_b = {w_cur_reg[1][DATA_W-1], w_cur_reg[1]};
                    end
                    TAP_CN_R:
                    begin
                        op_a = {cfg.coef_near_now[DATA_W-1], cfg.coef_near_now};
                        op_b = {w_cur_reg[3][DATA_W-1], w_cur_reg[3]};
                    end
                    TAP_CF_L:
                    begin
                        op_a = {cfg.coef_far_now[DATA_W-1], cfg.coef_far_now};
                        op_b = {w_cur_reg[0][DATA_W-1], w_cur_reg[0]};
                    end
                    TAP_CF_R:
                    begin
                        op_a = {cfg.coef_far_now[DATA_W-1], cfg.coef_far_now};
                        op_b = {w_cur_reg[4][DATA_W-1], w_cur_reg[4]};
                    end
                    TAP_PC:
                    begin
                        op_a = {cfg.coef_center_prev[DATA_W-1], cfg.coef_center_prev};
                        op_b = {w_prv_reg[1][DATA_W-1], w_prv_reg[1]};
                    end
                    TAP_PN_L:
                    begin
                        op_a = {cfg.coef_near_prev[DATA_W-1], cfg.coef_near_prev};
                        op_b = {w_prv_reg[0][DATA_W-1], w_prv_reg[0]};
                    end
                    TAP_PN_R:
                    begin
                        op_a = {cfg.coef_near_prev[DATA_W-1], cfg.coef_near_prev};
                        op_b = {w_prv_reg[2][DATA_W-1], w_prv_reg[2]};
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
                if (k_reg == TAP_PN_R)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = tap_t'(k_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                mac_ctrl.acc_add = 1'b1;
                state_next       = S_WRITE;
            end
            S_WRITE:
            begin
                mem_ctrl.wr_new  = 1'b1;
                mem_ctrl.wr_addr = l_reg;
                mem_ctrl.wr_data = stencil_res;
                if (l_reg == idx_reg)
                begin
                    pick_next = stencil_res;
                end
                l_next = l_reg + 1'b1;
                if (l_reg == eff_n - 1'b1)
                begin
                    state_next = S_END;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_END:
            begin
                mem_ctrl.wr_new  = 1'b1;
                mem_ctrl.wr_addr = eff_n;
                state_next       = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                op_a            = {pick_reg[DATA_W-1], pick_reg};
                op_b            = {{(OP_W-GAIN_W){1'b0}}, cfg.output_gain};
                mac_ctrl.mul_en = 1'b1;
                state_next      = S_OUT_RND;
            end
            S_OUT_RND:
            begin
                if (!out_valid || out_ready)
                begin
                    out_load   = 1'b1;
                    rotate     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
